/* hdl/max_heap_priority_queue_defines.svh */
// Assertion macros shared by the checker of the heap priority queue.
// Depends on nothing; expects i_clk and i_rst_n in the scope of use.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Clocked check, off while reset is held.
`define MHPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MHPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/mhpq_pkg.sv */
// Shared types and constants of the heap priority queue.
// No dependencies.
package mhpq_pkg;

    localparam int KEY_W      = 32;
    localparam int ENTRIES_W  = 11;
    localparam int STATUS_W   = 2;
    localparam int HEAP_DEPTH = 1024;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_LAST,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_DONE
    } t_state;

endpackage

/* hdl/mhpq_if.sv */
// Valid/ready channels of the heap priority queue: request and result.
// Depends on mhpq_pkg.
interface mhpq_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   func;
    logic signed [mhpq_pkg::KEY_W-1:0]      value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface mhpq_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [mhpq_pkg::KEY_W-1:0]      removed_key;
    logic signed [mhpq_pkg::KEY_W-1:0]      top_key;
    logic        [mhpq_pkg::ENTRIES_W-1:0]  entries;
    logic        [mhpq_pkg::STATUS_W-1:0]   status;

    modport source (output valid, output removed_key, output top_key, output entries,
                    output status, input ready);
    modport sink   (input valid, input removed_key, input top_key, input entries,
                    input status, output ready);
endinterface

/* hdl/max_heap_priority_queue.sv */
// Binary max-heap priority queue: top level with the sift sequencer.
// Depends on mhpq_pkg, mhpq_if and mhpq_ram.
//
// Each request word is an insert (func 0) or a delete-top (func 1) and gives
// one result word: removed key, new top key, entry count and status. Keys
// live in one RAM (slot n at address n-1) with a registered read port; the
// key being sifted is held in a register and written once, into the slot
// where it stops, while each level moves the key it passes into the slot it
// leaves; a copy of the root sits in a register so the top key is known
// without a read. The block takes one request at a time and drops ready
// until its result is loaded into the output register. A key travels at
// most log2 of the depth levels on an insert (10 for 1024 entries) and one
// less on a delete. Each level of sift-up is one parent read and a compare,
// each level of sift-down is two child reads over the single RAM read port
// and a compare. Refused operations (insert when full, delete when empty)
// and the delete of the only key go from idle straight to the final state.
// A stalled result port holds the block in its final state until the result
// word is taken. The RAM is not cleared; only slots up to the count are
// ever used.
module max_heap_priority_queue #(
    parameter int HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mhpq_in_if.sink     i_in,
    mhpq_out_if.source  o_out
);

    localparam int AW    = $clog2(HEAP_DEPTH);        // RAM address
    localparam int CW    = $clog2(HEAP_DEPTH + 1);    // slot number / count
    localparam int EXT_W = CW + mhpq_pkg::ENTRIES_W;
    localparam int KW    = mhpq_pkg::KEY_W;

    mhpq_pkg::t_state r_state, n_state;

    logic        [CW-1:0]   r_count, n_count;
    logic        [CW-1:0]   r_pos, n_pos;         // slot the moving key sits at
    logic signed [KW-1:0]   r_key, n_key;         // key being sifted
    logic signed [KW-1:0]   r_lval, n_lval;       // left child during sift-down
    logic signed [KW-1:0]   r_top, n_top;         // copy of slot 1
    logic signed [KW-1:0]   r_removed, n_removed;
    logic [mhpq_pkg::STATUS_W-1:0] r_status, n_status;

    // output register
    logic                   r_out_valid;
    logic signed [KW-1:0]   r_out_removed;
    logic signed [KW-1:0]   r_out_top;
    logic [mhpq_pkg::ENTRIES_W-1:0] r_out_entries;
    logic [mhpq_pkg::STATUS_W-1:0]  r_out_status;

    // RAM port
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [KW-1:0]  ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [KW-1:0]  ram_rdata;

    // sequencer helpers
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_load_out;
    logic [CW-1:0]        w_pos_m1;
    logic [CW-1:0]        w_parent;
    logic [CW-1:0]        w_parent_m1;
    logic [CW-1:0]        w_count_m1;
    logic [CW:0]          w_child;
    logic [CW:0]          w_child_m1;
    logic [CW:0]          w_child_p1;
    logic                 w_no_child;
    logic                 w_has_right;
    logic signed [KW-1:0] w_rd_key;
    logic                 w_up_swap;
    logic                 w_pick_right;
    logic signed [KW-1:0] w_big_val;
    logic [CW-1:0]        w_big_slot;
    logic                 w_dn_swap;
    logic [EXT_W-1:0]     w_count_ext;

    mhpq_ram #(
        .WIDTH (KW),
        .DEPTH (HEAP_DEPTH),
        .ADDR_W(AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign i_in.ready  = (r_state == mhpq_pkg::ST_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_load_out  = (r_state == mhpq_pkg::ST_DONE) && w_out_free;

    assign w_pos_m1    = r_pos - CW'(1);
    assign w_parent    = r_pos >> 1;
    assign w_parent_m1 = w_parent - CW'(1);
    assign w_count_m1  = r_count - CW'(1);
    assign w_child     = {r_pos, 1'b0};
    assign w_child_m1  = w_child - (CW+1)'(1);
    assign w_child_p1  = w_child + (CW+1)'(1);
    assign w_no_child  = w_child > {1'b0, r_count};
    assign w_has_right = w_child < {1'b0, r_count};

    // compare unit: sift-up swaps while the moving key beats the parent,
    // sift-down picks the larger child (left wins a tie) and tests it
    // against the moving key
    assign w_rd_key     = $signed(ram_rdata);
    assign w_up_swap    = r_key > w_rd_key;
    assign w_pick_right = w_has_right && (w_rd_key > r_lval);
    assign w_big_val    = w_pick_right ? w_rd_key : r_lval;
    assign w_big_slot   = w_pick_right ? w_child_p1[CW-1:0] : w_child[CW-1:0];
    assign w_dn_swap    = w_big_val > r_key;

    // entry count is reported modulo 2^11
    assign w_count_ext  = {{mhpq_pkg::ENTRIES_W{1'b0}}, r_count};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mhpq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_in.func == mhpq_pkg::FUNC_INSERT) begin
                        n_state = (r_count >= CW'(HEAP_DEPTH)) ? mhpq_pkg::ST_DONE
                                                              : mhpq_pkg::ST_UP_RD;
                    end else begin
                        n_state = (r_count > CW'(1)) ? mhpq_pkg::ST_LAST
                                                     : mhpq_pkg::ST_DONE;
                    end
                end
            end
            mhpq_pkg::ST_UP_RD: begin
                n_state = (r_pos == CW'(1)) ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_UP_CMP;
            end
            mhpq_pkg::ST_UP_CMP: begin
                n_state = w_up_swap ? mhpq_pkg::ST_UP_RD : mhpq_pkg::ST_DONE;
            end
            mhpq_pkg::ST_LAST: begin
                n_state = mhpq_pkg::ST_DN_RDL;
            end
            mhpq_pkg::ST_DN_RDL: begin
                n_state = w_no_child ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_DN_RDR;
            end
            mhpq_pkg::ST_DN_RDR: begin
                n_state = mhpq_pkg::ST_DN_CMP;
            end
            mhpq_pkg::ST_DN_CMP: begin
                n_state = w_dn_swap ? mhpq_pkg::ST_DN_RDL : mhpq_pkg::ST_DONE;
            end
            mhpq_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = mhpq_pkg::ST_IDLE;
                end
            end
            default: n_state = mhpq_pkg::ST_IDLE;
        endcase
    end

    // datapath and RAM controls
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = w_pos_m1[AW-1:0];
        ram_wdata = r_key;
        ram_raddr = w_parent_m1[AW-1:0];
        n_count   = r_count;
        n_pos     = r_pos;
        n_key     = r_key;
        n_lval    = r_lval;
        n_removed = r_removed;
        n_status  = r_status;
        unique case (r_state)
            mhpq_pkg::ST_IDLE: begin
                // last slot is fetched up front for a delete
                ram_raddr = w_count_m1[AW-1:0];
                if (w_accept) begin
                    n_removed = '0;
                    n_status  = mhpq_pkg::STATUS_OK;
                    if (i_in.func == mhpq_pkg::FUNC_INSERT) begin
                        if (r_count >= CW'(HEAP_DEPTH)) begin
                            n_status = mhpq_pkg::STATUS_FULL;
                        end else begin
                            n_count = r_count + CW'(1);
                            n_pos   = r_count + CW'(1);
                            n_key   = i_in.value;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = mhpq_pkg::STATUS_EMPTY;
                        end else begin
                            n_removed = r_top;
                            n_count   = w_count_m1;
                        end
                    end
                end
            end
            mhpq_pkg::ST_UP_RD: begin
                if (r_pos == CW'(1)) begin
                    ram_we = 1'b1;
                end
            end
            mhpq_pkg::ST_UP_CMP: begin
                ram_we = 1'b1;
                if (w_up_swap) begin
                    ram_wdata = ram_rdata;
                    n_pos     = w_parent;
                end
            end
            mhpq_pkg::ST_LAST: begin
                n_key = w_rd_key;
                n_pos = CW'(1);
            end
            mhpq_pkg::ST_DN_RDL: begin
                ram_raddr = w_child_m1[AW-1:0];
                if (w_no_child) begin
                    ram_we = 1'b1;
                end
            end
            mhpq_pkg::ST_DN_RDR: begin
                // right child lives at address equal to the left slot number
                ram_raddr = w_child[AW-1:0];
                n_lval    = w_rd_key;
            end
            mhpq_pkg::ST_DN_CMP: begin
                ram_we = 1'b1;
                if (w_dn_swap) begin
                    ram_wdata = w_big_val;
                    n_pos     = w_big_slot;
                end
            end
            mhpq_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
        // keep the root copy in step with every write to slot 1
        n_top = r_top;
        if (ram_we && (ram_waddr == '0)) begin
            n_top = $signed(ram_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mhpq_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_key     <= n_key;
        r_lval    <= n_lval;
        r_top     <= n_top;
        r_removed <= n_removed;
        r_status  <= n_status;
        if (w_load_out) begin
            r_out_removed <= r_removed;
            r_out_top     <= (r_count != '0) ? r_top : '0;
            r_out_entries <= w_count_ext[mhpq_pkg::ENTRIES_W-1:0];
            r_out_status  <= r_status;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.removed_key = r_out_removed;
    assign o_out.top_key     = r_out_top;
    assign o_out.entries     = r_out_entries;
    assign o_out.status      = r_out_status;

endmodule

/* hdl/mhpq_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mhpq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/mhpq_checker.sv */
// Port-level checks of the heap priority queue, bound to the top level.
// Depends on mhpq_pkg and max_heap_priority_queue_defines.svh.
`include "max_heap_priority_queue_defines.svh"

module mhpq_checker #(
    parameter int HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [mhpq_pkg::KEY_W-1:0]        i_out_removed_key,
    input logic [mhpq_pkg::KEY_W-1:0]        i_out_top_key,
    input logic [mhpq_pkg::ENTRIES_W-1:0]    i_out_entries,
    input logic [mhpq_pkg::STATUS_W-1:0]     i_out_status
);

    localparam logic [mhpq_pkg::ENTRIES_W-1:0] FULL_ENTRIES =
        mhpq_pkg::ENTRIES_W'(HEAP_DEPTH);

    // a stalled result word holds
    `MHPQ_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_out_removed_key, i_out_top_key, i_out_entries, i_out_status}), "result changed while stalled")

    // one request at a time: busy right after taking a word
    `MHPQ_ASSERT(a_busy_after_accept, i_in_valid && i_in_ready |=> !i_in_ready, "ready stayed high after accept")

    // a refused insert reports a full heap
    `MHPQ_ASSERT(a_full_count, i_out_valid && (i_out_status == mhpq_pkg::STATUS_FULL) |-> i_out_entries == FULL_ENTRIES && i_out_removed_key == '0, "full refusal with wrong count")

    // a refused delete reports an empty heap
    `MHPQ_ASSERT(a_empty_result, i_out_valid && (i_out_status == mhpq_pkg::STATUS_EMPTY) |-> i_out_entries == '0 && i_out_top_key == '0 && i_out_removed_key == '0, "empty refusal with nonzero fields")

endmodule

bind max_heap_priority_queue mhpq_checker #(
    .HEAP_DEPTH(HEAP_DEPTH)
) u_mhpq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_removed_key(o_out.removed_key),
    .i_out_top_key    (o_out.top_key),
    .i_out_entries    (o_out.entries),
    .i_out_status     (o_out.status)
);
